// ===== src/dbdcs_pkg.sv =====
`timescale 1ns / 1ps

package dbdcs_pkg;

    // Fixed field widths of the stream words.
    localparam int OP_W     = 3;
    localparam int ID_W     = 12;
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int STATUS_W = 2;

    localparam int S_FIELDS_W = ID_W + IDX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_FIELDS_W = ID_W + 2 * CNT_W + STATUS_W + 2;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUT      = 3'd0,
        OP_SWAP     = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_READ_CUR = 3'd3,
        OP_READ_NXT = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REMOVE,
        ST_SWEEP,
        ST_HOLD
    } state_t;

    localparam logic [STATUS_W-1:0] SYNC_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] SYNC_SINGLE = 2'd1;
    localparam logic [STATUS_W-1:0] SYNC_MULTI  = 2'd2;

endpackage

// ===== src/double_buffered_dedup_candidate_set_core.sv =====
// Channel   Direction  Group                       Contents
// s_        in         s_tvalid s_tready           s_tdata: room_id, index; s_tuser: opcode
// m_        out        m_tvalid m_tready           m_tdata: read_id, current_count,
//                                                  next_count, sync_status, accepted,
//                                                  overflow; m_tuser: read_valid
//
// Put, swap, read and unknown opcodes accept the word and read the memories in ST_IDLE,
// then update and write back in ST_EXEC.
// A remove streams the current list through a three-stage read, mark read, write
// pipeline at one entry per cycle.
// Reset, a clear word and an epoch wrap sweep all ROOM_COUNT entries of the mark store,
// one entry per cycle; no word is accepted during the sweep.
// A finished result waits in the output register; the block stalls only if a further
// result is ready while that register is still full.
`timescale 1ns / 1ps

module double_buffered_dedup_candidate_set_core #(
    parameter int ROOM_COUNT = 4096,
    parameter int LIST_DEPTH = 256,
    parameter int EPOCH_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dbdcs_pkg::S_TDATA_W-1:0]  s_tdata,  // room_id, index
    input  logic [dbdcs_pkg::S_TUSER_W-1:0]  s_tuser,  // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dbdcs_pkg::M_TDATA_W-1:0]  m_tdata,  // read_id, current_count, next_count,
                                                       // sync_status, accepted, overflow
    output logic [dbdcs_pkg::M_TUSER_W-1:0]  m_tuser   // read_valid
);

    import dbdcs_pkg::*;

    localparam int MW         = $clog2(ROOM_COUNT);
    localparam int IW         = $clog2(LIST_DEPTH);
    localparam int LAW        = IW + 1;
    localparam int LIST_SLOTS = 2 ** LAW;
    localparam int CW         = $clog2(LIST_DEPTH + 1);
    localparam int EW         = EPOCH_BITS;

    // Memories: one mark per id, and both lists side by side, the bank bit on top.
    logic [EW-1:0]   mark_mem [ROOM_COUNT];
    logic [ID_W-1:0] list_mem [LIST_SLOTS];

    logic [EW-1:0]   mark_rdata_reg;
    logic [ID_W-1:0] list_rdata_reg;

    logic            mark_we;
    logic [MW-1:0]   mark_waddr;
    logic [EW-1:0]   mark_wdata;
    logic [MW-1:0]   mark_raddr;
    logic            list_we;
    logic [LAW-1:0]  list_waddr;
    logic [ID_W-1:0] list_wdata;
    logic [LAW-1:0]  list_raddr;

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]   count_a_reg, count_a_next;
    logic [CW-1:0]   count_b_reg, count_b_next;
    logic            bank_reg, bank_next;
    logic [EW-1:0]   epoch_reg, epoch_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            vb_reg, vb_next;
    logic            vc_reg, vc_next;
    logic [ID_W-1:0] idc_reg, idc_next;
    logic            wrote_reg, wrote_next;
    logic [ID_W-1:0] wrote_id_reg, wrote_id_next;
    logic [MW-1:0]   sweep_idx_reg, sweep_idx_next;
    logic            sweep_pend_reg, sweep_pend_next;
    logic            acc_reg, acc_next;
    logic            ovf_reg, ovf_next;
    logic            rvalid_reg, rvalid_next;
    logic [ID_W-1:0] rid_reg, rid_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic            accept;
    logic [ID_W-1:0] in_id;
    logic [IDX_W-1:0] in_idx;
    op_t             in_op;
    logic [CW-1:0]   cur_cnt;
    logic [CW-1:0]   nxt_cnt;
    logic            nxt_full;
    logic            issue_a;
    logic            rm_done;
    logic            wrap;
    logic            sweep_last;
    logic            out_free;
    logic            finish;
    logic            ent_keep;
    logic            seen_c;
    logic            put_new;

    assign in_id  = s_tdata[ID_W-1:0];
    assign in_idx = s_tdata[ID_W +: IDX_W];
    assign in_op  = op_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign cur_cnt    = bank_reg ? count_b_reg : count_a_reg;
    assign nxt_cnt    = bank_reg ? count_a_reg : count_b_reg;
    assign nxt_full   = (nxt_cnt == CW'(LIST_DEPTH));
    assign issue_a    = (rd_idx_reg < cur_cnt);
    assign rm_done    = (state_reg == ST_REMOVE) && !issue_a && !vb_reg && !vc_reg;
    assign wrap       = (epoch_reg == {EW{1'b1}});
    assign sweep_last = (sweep_idx_reg == MW'(ROOM_COUNT - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // An entry leaving stage B is kept unless it is the removed id or lies beyond the store.
    assign ent_keep = (list_rdata_reg != id_reg) && (32'(list_rdata_reg) < ROOM_COUNT);
    // The mark written in the previous cycle has not reached the read data yet.
    assign seen_c   = (wrote_reg && (wrote_id_reg == idc_reg))
                      || (mark_rdata_reg == epoch_reg);
    assign put_new  = (32'(id_reg) < ROOM_COUNT) && (mark_rdata_reg != epoch_reg);

    assign finish = ((state_reg == ST_EXEC) && (op_reg != OP_REMOVE) && (op_reg != OP_CLEAR)
                        && !((op_reg == OP_SWAP) && wrap))
                    || (rm_done && !wrap)
                    || ((state_reg == ST_SWEEP) && sweep_last && sweep_pend_reg)
                    || (state_reg == ST_HOLD);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (op_reg == OP_REMOVE)
                    state_next = ST_REMOVE;
                else if (!finish)
                    state_next = ST_SWEEP;
                else
                    state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_REMOVE:
            begin
                if (rm_done)
                begin
                    if (wrap)
                        state_next = ST_SWEEP;
                    else
                        state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    if (sweep_pend_reg && !out_free)
                        state_next = ST_HOLD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic            do_swap;
        logic            nxt_inc;
        logic [CW-1:0]   cc;
        logic [CW-1:0]   nc;
        logic [STATUS_W-1:0] status;

        do_swap         = 1'b0;
        nxt_inc         = 1'b0;
        op_next         = op_reg;
        id_next         = id_reg;
        idx_next        = idx_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        bank_next       = bank_reg;
        epoch_next      = epoch_reg;
        rd_idx_next     = rd_idx_reg;
        vb_next         = 1'b0;
        vc_next         = 1'b0;
        idc_next        = idc_reg;
        wrote_next      = 1'b0;
        wrote_id_next   = wrote_id_reg;
        sweep_idx_next  = sweep_idx_reg;
        sweep_pend_next = sweep_pend_reg;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        rvalid_next     = rvalid_reg;
        rid_next        = rid_reg;

        mark_we    = 1'b0;
        mark_waddr = MW'(id_reg);
        mark_wdata = epoch_reg;
        mark_raddr = MW'(in_id);
        list_we    = 1'b0;
        list_waddr = {~bank_reg, IW'(nxt_cnt)};
        list_wdata = id_reg;
        list_raddr = {(in_op == OP_READ_NXT) ? ~bank_reg : bank_reg, IW'(in_idx)};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    id_next     = in_id;
                    idx_next    = in_idx;
                    acc_next    = 1'b0;
                    ovf_next    = 1'b0;
                    rvalid_next = 1'b0;
                    rid_next    = '0;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (put_new)
                        begin
                            if (nxt_full)
                                ovf_next = 1'b1;
                            else
                            begin
                                list_we  = 1'b1;
                                mark_we  = 1'b1;
                                nxt_inc  = 1'b1;
                                acc_next = 1'b1;
                            end
                        end
                    end
                    OP_SWAP:
                    begin
                        do_swap = 1'b1;
                    end
                    OP_REMOVE:
                    begin
                        rd_idx_next = '0;
                    end
                    OP_READ_CUR:
                    begin
                        rvalid_next = (32'(idx_reg) < 32'(cur_cnt));
                        rid_next    = rvalid_next ? list_rdata_reg : '0;
                    end
                    OP_READ_NXT:
                    begin
                        rvalid_next = (32'(idx_reg) < 32'(nxt_cnt));
                        rid_next    = rvalid_next ? list_rdata_reg : '0;
                    end
                    OP_CLEAR:
                    begin
                        count_a_next    = '0;
                        count_b_next    = '0;
                        bank_next       = 1'b1;
                        epoch_next      = EW'(2);
                        sweep_idx_next  = '0;
                        sweep_pend_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_REMOVE:
            begin
                // Stage A: fetch the next entry of the current list.
                list_raddr = {bank_reg, IW'(rd_idx_reg)};
                if (issue_a)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    vb_next     = 1'b1;
                end
                // Stage B: fetch the mark of that entry.
                mark_raddr = MW'(list_rdata_reg);
                if (vb_reg && ent_keep)
                begin
                    vc_next  = 1'b1;
                    idc_next = list_rdata_reg;
                end
                // Stage C: append it unless it is already marked this epoch or the next list is full.
                mark_waddr = MW'(idc_reg);
                list_wdata = idc_reg;
                if (vc_reg && !seen_c)
                begin
                    if (nxt_full)
                        ovf_next = 1'b1;
                    else
                    begin
                        list_we       = 1'b1;
                        mark_we       = 1'b1;
                        nxt_inc       = 1'b1;
                        wrote_next    = 1'b1;
                        wrote_id_next = idc_reg;
                    end
                end
                if (rm_done)
                    do_swap = 1'b1;
            end
            ST_SWEEP:
            begin
                mark_we    = 1'b1;
                mark_waddr = sweep_idx_reg;
                mark_wdata = '0;
                if (!sweep_last)
                    sweep_idx_next = sweep_idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (nxt_inc)
        begin
            if (bank_reg)
                count_a_next = count_a_reg + 1'b1;
            else
                count_b_next = count_b_reg + 1'b1;
        end

        if (do_swap)
        begin
            epoch_next = wrap ? EW'(1) : epoch_reg + 1'b1;
            bank_next  = ~bank_reg;
            // The old current list becomes the new, empty next list.
            if (bank_reg)
                count_b_next = '0;
            else
                count_a_next = '0;
            if (wrap)
            begin
                sweep_idx_next  = '0;
                sweep_pend_next = 1'b1;
            end
        end

        cc = bank_next ? count_b_next : count_a_next;
        nc = bank_next ? count_a_next : count_b_next;
        if (cc == CW'(0))
            status = SYNC_NONE;
        else if (cc == CW'(1))
            status = SYNC_SINGLE;
        else
            status = SYNC_MULTI;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (finish && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({ovf_next, acc_next, status, CNT_W'(nc), CNT_W'(cc),
                                        rid_next});
            m_tuser_next  = M_TUSER_W'(rvalid_next);
            sweep_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        mark_rdata_reg <= mark_mem[mark_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_waddr] <= list_wdata;
        list_rdata_reg <= list_mem[list_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            bank_reg       <= 1'b1;
            epoch_reg      <= EW'(2);
            rd_idx_reg     <= '0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            wrote_reg      <= 1'b0;
            sweep_idx_reg  <= '0;
            sweep_pend_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            bank_reg       <= bank_next;
            epoch_reg      <= epoch_next;
            rd_idx_reg     <= rd_idx_next;
            vb_reg         <= vb_next;
            vc_reg         <= vc_next;
            wrote_reg      <= wrote_next;
            sweep_idx_reg  <= sweep_idx_next;
            sweep_pend_reg <= sweep_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        idx_reg      <= idx_next;
        idc_reg      <= idc_next;
        wrote_id_reg <= wrote_id_next;
        acc_reg      <= acc_next;
        ovf_reg      <= ovf_next;
        rvalid_reg   <= rvalid_next;
        rid_reg      <= rid_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_a_reg) <= LIST_DEPTH) && (32'(count_b_reg) <= LIST_DEPTH))
        else $error("list count beyond list depth");

    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch reached zero");

    a_stage_c_fed: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg |-> $past(vb_reg))
        else $error("remove pipeline stage C valid without stage B");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    a_remove_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE) |-> (rd_idx_reg <= cur_cnt))
        else $error("remove walk beyond current count");

endmodule
